### rtl/core/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg
// Shared types and constants for the sphere view cull core: register map,
// cull reason codes, camera settings bundle and projection beat layout.
// ----------------------------------------------------------------------------
package svc_pkg;

	// Widths of the fixed point values
	localparam int unsigned PosW   = 20;  // Q12.8 position
	localparam int unsigned RelW   = 21;  // position minus camera
	localparam int unsigned RotW   = 16;  // Q1.14 rotation weight
	localparam int unsigned ProdW  = 37;  // RelW + RotW
	localparam int unsigned ProjW  = 39;  // sum of three products, Q.22
	localparam int unsigned RadW   = 19;  // Q11.8 radius
	localparam int unsigned OwnerW = 16;
	localparam int unsigned RateW  = 16;  // Q4.12 rate
	localparam int unsigned BaseW  = 40;  // forward + radius, Q.22
	localparam int unsigned LimW   = 57;  // rate * base, Q.34
	localparam int unsigned CmpW   = 58;  // lateral compare width
	localparam int unsigned IdxW   = 3;
	localparam int unsigned DataW  = 60;

	// Register indexes
	typedef enum logic [IdxW-1:0] {
		REG_CAM_POSITION = 3'd0,
		REG_ROT_RIGHT    = 3'd1,
		REG_ROT_FORWARD  = 3'd2,
		REG_ROT_UP       = 3'd3,
		REG_CLIP_RANGE   = 3'd4,
		REG_VIEW_RATES   = 3'd5,
		REG_HIDE_OWNER   = 3'd6
	} cfg_reg_t;

	// Cull reason codes, first failing test wins
	typedef enum logic [2:0] {
		REASON_VISIBLE  = 3'd0,
		REASON_OWNER    = 3'd1,
		REASON_FAR      = 3'd2,
		REASON_NEAR     = 3'd3,
		REASON_SIDEWAYS = 3'd4,
		REASON_VERTICAL = 3'd5
	} reason_t;

	// Reset values of the rotation rows (x weight 1.0)
	localparam logic [47:0] ROT_RESET = 48'd16384;

	// Camera settings as held in the register bank
	typedef struct packed {
		logic [59:0] cam_position;
		logic [47:0] rot_right;
		logic [47:0] rot_forward;
		logic [47:0] rot_up;
		logic [39:0] clip_range;
		logic [31:0] view_rates;
		logic [15:0] hide_owner;
	} cfg_t;

	// Beat passed from the projection stages to the limit stages
	typedef struct packed {
		logic signed [ProjW-1:0] right;
		logic signed [ProjW-1:0] fwd;
		logic signed [ProjW-1:0] up;
		logic        [RadW-1:0]  radius;
		logic                    hit;
	} proj_t;

endpackage

### rtl/core/svc_project.sv
// ----------------------------------------------------------------------------
// svc_project
// Stages 1 to 3: camera relative position, nine weight products, axis sums.
// ----------------------------------------------------------------------------
module svc_project (
	input  logic                 clk,
	input  logic                 arst_n,
	input  svc_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [19:0]   pos_x,
	input  logic signed [19:0]   pos_y,
	input  logic signed [19:0]   pos_z,
	input  logic        [18:0]   bound_radius,
	input  logic        [15:0]   owner_id,
	output logic                 out_valid,
	input  logic                 out_ready,
	output svc_pkg::proj_t       out_beat
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [svc_pkg::RelW-1:0]  rel_s1 [3];
	logic        [svc_pkg::RadW-1:0]  radius_s1, radius_s2;
	logic                             hit_s1, hit_s2;

	logic signed [svc_pkg::ProdW-1:0] prod_s2 [3][3];
	svc_pkg::proj_t                   beat_s3;

	logic signed [svc_pkg::PosW-1:0]  pos [3];
	logic signed [svc_pkg::RelW-1:0]  rel_d [3];
	logic        [47:0]               rot [3];
	logic signed [svc_pkg::ProdW-1:0] prod_d [3][3];
	logic signed [svc_pkg::ProjW-1:0] sum_d [3];

	// Ready chain: a stage takes a beat when empty or moving on
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Position minus camera
	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rel_d[k] = svc_pkg::RelW'(pos[k])
				- svc_pkg::RelW'($signed(cfg.cam_position[20*k +: 20]));
		end
	end

	// One weight times one coordinate per product
	assign rot[0] = cfg.rot_right;
	assign rot[1] = cfg.rot_forward;
	assign rot[2] = cfg.rot_up;
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 3; k++) begin
				prod_d[a][k] = rel_s1[k] * $signed(rot[a][16*k +: 16]);
			end
		end
	end

	// Axis sums
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum_d[a] = svc_pkg::ProjW'(prod_s2[a][0]) + svc_pkg::ProjW'(prod_s2[a][1])
				+ svc_pkg::ProjW'(prod_s2[a][2]);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1 data
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			rel_s1    <= rel_d;
			radius_s1 <= bound_radius;
			hit_s1    <= (owner_id == cfg.hide_owner);
		end
	end

	// Stage 2 data
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			prod_s2   <= prod_d;
			radius_s2 <= radius_s1;
			hit_s2    <= hit_s1;
		end
	end

	// Stage 3 data
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			beat_s3.right  <= sum_d[0];
			beat_s3.fwd    <= sum_d[1];
			beat_s3.up     <= sum_d[2];
			beat_s3.radius <= radius_s2;
			beat_s3.hit    <= hit_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_beat  = beat_s3;

endmodule

### rtl/core/svc_limit.sv
// ----------------------------------------------------------------------------
// svc_limit
// Stages 4 to 6: clip tests and lateral base, rate products, lateral tests
// and the final cull reason.
// ----------------------------------------------------------------------------
module svc_limit (
	input  logic               clk,
	input  logic               arst_n,
	input  svc_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  svc_pkg::proj_t     in_beat,
	output logic               out_valid,
	input  logic               out_ready,
	output svc_pkg::reason_t   out_reason
);

	logic v_s4, v_s5, v_s6;
	logic rdy_s4, rdy_s5, rdy_s6;

	logic signed [svc_pkg::ProjW-1:0] right_s4, up_s4, right_s5, up_s5;
	logic signed [svc_pkg::BaseW-1:0] base_s4;
	logic        [svc_pkg::RadW-1:0]  radius_s4, radius_s5;
	logic                             hit_s4, far_s4, near_s4;
	logic                             hit_s5, far_s5, near_s5;
	logic signed [svc_pkg::LimW-1:0]  rprod_s5, uprod_s5;
	svc_pkg::reason_t                 reason_s6;

	logic signed [20:0]                near_sum, far_sum;
	logic signed [svc_pkg::ProjW-1:0]  dir_min, dir_max;
	logic signed [svc_pkg::BaseW-1:0]  base_d;
	logic signed [16:0]                rate_h, rate_v;
	logic signed [svc_pkg::LimW-1:0]   rprod_d, uprod_d;
	logic signed [svc_pkg::CmpW-1:0]   rad_q34, rlim, ulim, rp, up_p;
	logic                              r_fail, u_fail;
	svc_pkg::reason_t                  reason_d;

	// Ready chain
	assign rdy_s6   = !v_s6 || out_ready;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	// Clip window in Q.22, near pulled in and far pushed out by the radius
	assign near_sum = 21'($signed(cfg.clip_range[19:0])) - $signed({2'b00, in_beat.radius});
	assign far_sum  = 21'($signed(cfg.clip_range[39:20])) + $signed({2'b00, in_beat.radius});
	assign dir_min  = svc_pkg::ProjW'($signed({near_sum, 14'b0}));
	assign dir_max  = svc_pkg::ProjW'($signed({far_sum, 14'b0}));
	assign base_d   = svc_pkg::BaseW'(in_beat.fwd) + $signed({7'b0, in_beat.radius, 14'b0});

	// Rate products, Q.34
	assign rate_h  = $signed({1'b0, cfg.view_rates[15:0]});
	assign rate_v  = $signed({1'b0, cfg.view_rates[31:16]});
	assign rprod_d = rate_h * base_s4;
	assign uprod_d = rate_v * base_s4;

	// Lateral limits and symmetric tests
	assign rad_q34 = $signed({13'b0, radius_s5, 26'b0});
	assign rlim    = svc_pkg::CmpW'(rprod_s5) + rad_q34;
	assign ulim    = svc_pkg::CmpW'(uprod_s5) + rad_q34;
	assign rp      = svc_pkg::CmpW'($signed({right_s5, 12'b0}));
	assign up_p    = svc_pkg::CmpW'($signed({up_s5, 12'b0}));
	assign r_fail  = (rp > rlim) || (-rp > rlim);
	assign u_fail  = (up_p > ulim) || (-up_p > ulim);

	// First failing test wins
	always_comb begin
		priority if (hit_s5)  reason_d = svc_pkg::REASON_OWNER;
		else if (far_s5)      reason_d = svc_pkg::REASON_FAR;
		else if (near_s5)     reason_d = svc_pkg::REASON_NEAR;
		else if (r_fail)      reason_d = svc_pkg::REASON_SIDEWAYS;
		else if (u_fail)      reason_d = svc_pkg::REASON_VERTICAL;
		else                  reason_d = svc_pkg::REASON_VISIBLE;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= in_valid;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 4 data
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s4) begin
			right_s4  <= in_beat.right;
			up_s4     <= in_beat.up;
			base_s4   <= base_d;
			radius_s4 <= in_beat.radius;
			hit_s4    <= in_beat.hit;
			far_s4    <= (in_beat.fwd > dir_max);
			near_s4   <= (in_beat.fwd < dir_min);
		end
	end

	// Stage 5 data
	always_ff @(posedge clk) begin
		if (v_s4 && rdy_s5) begin
			right_s5  <= right_s4;
			up_s5     <= up_s4;
			rprod_s5  <= rprod_d;
			uprod_s5  <= uprod_d;
			radius_s5 <= radius_s4;
			hit_s5    <= hit_s4;
			far_s5    <= far_s4;
			near_s5   <= near_s4;
		end
	end

	// Stage 6 result register
	always_ff @(posedge clk) begin
		if (v_s5 && rdy_s6) begin
			reason_s6 <= reason_d;
		end
	end

	assign out_valid  = v_s6;
	assign out_reason = reason_s6;

	// A hidden owner always reports the owner reason
	a_owner_first: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && rdy_s6 && hit_s5 |=> reason_s6 == svc_pkg::REASON_OWNER)
		else $error("hidden owner not reported first");

	// Far test outranks the later tests
	a_far_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && rdy_s6 && !hit_s5 && far_s5 |=> reason_s6 == svc_pkg::REASON_FAR)
		else $error("far cull not reported");

	// A waiting result keeps its reason
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !out_ready |=> v_s6 && $stable(reason_s6))
		else $error("held result changed");

	// A beat in stage 5 is never dropped while stage 6 is blocked
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !rdy_s6 |=> v_s5)
		else $error("stage 5 beat lost");

endmodule

### rtl/core/sphere_view_cull_core.sv
// ----------------------------------------------------------------------------
// sphere_view_cull_core
// Bounding sphere view cull: visible flag and first failing cull reason
// for each model instance against the configured camera.
// ----------------------------------------------------------------------------
// Usage: the core takes one instance per clock cycle unless item_stall is
// high and returns each result in order through six pipeline stages (camera
// offset, weight products, axis sums, clip tests, rate products, lateral
// tests); a stalled result holds only the stages behind it while empty
// stages keep filling. The configuration port is always ready; write the
// camera registers only while no instance is in flight, an out of range
// index is dropped.
// ----------------------------------------------------------------------------
module sphere_view_cull_core (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [59:0]        cfg_data,
	// instance channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [19:0] pos_x,
	input  logic signed [19:0] pos_y,
	input  logic signed [19:0] pos_z,
	input  logic        [18:0] bound_radius,
	input  logic        [15:0] owner_id,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic               visible,
	output logic [2:0]         cull_reason
);

	svc_pkg::cfg_t    cfg_q;
	svc_pkg::proj_t   proj_beat;
	svc_pkg::reason_t reason;
	logic             proj_valid, limit_ready, item_ready;

	assign cfg_ready = 1'b1;

	// Register bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_position <= '0;
			cfg_q.rot_right    <= svc_pkg::ROT_RESET;
			cfg_q.rot_forward  <= svc_pkg::ROT_RESET;
			cfg_q.rot_up       <= svc_pkg::ROT_RESET;
			cfg_q.clip_range   <= '0;
			cfg_q.view_rates   <= '0;
			cfg_q.hide_owner   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (svc_pkg::cfg_reg_t'(cfg_index))
				svc_pkg::REG_CAM_POSITION: cfg_q.cam_position <= cfg_data;
				svc_pkg::REG_ROT_RIGHT:    cfg_q.rot_right    <= cfg_data[47:0];
				svc_pkg::REG_ROT_FORWARD:  cfg_q.rot_forward  <= cfg_data[47:0];
				svc_pkg::REG_ROT_UP:       cfg_q.rot_up       <= cfg_data[47:0];
				svc_pkg::REG_CLIP_RANGE:   cfg_q.clip_range   <= cfg_data[39:0];
				svc_pkg::REG_VIEW_RATES:   cfg_q.view_rates   <= cfg_data[31:0];
				svc_pkg::REG_HIDE_OWNER:   cfg_q.hide_owner   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Projection stages
	svc_project u_project (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (item_valid),
		.in_ready     (item_ready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.bound_radius (bound_radius),
		.owner_id     (owner_id),
		.out_valid    (proj_valid),
		.out_ready    (limit_ready),
		.out_beat     (proj_beat)
	);

	// Limit and decision stages
	svc_limit u_limit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (proj_valid),
		.in_ready   (limit_ready),
		.in_beat    (proj_beat),
		.out_valid  (result_valid),
		.out_ready  (!result_stall),
		.out_reason (reason)
	);

	assign item_stall  = !item_ready;
	assign cull_reason = reason;
	assign visible     = (reason == svc_pkg::REASON_VISIBLE);

endmodule

### verif/tb_sphere_view_cull_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_view_cull_core
// Self-checking bench for the sphere view cull core. A shadow copy of the
// camera registers feeds a fixed point verdict predictor. Directed tests
// cover each cull reason, the clip edges, a negative lateral limit and an
// unmapped register write. Random scenes follow under several camera
// settings and idle/stall mixes. Each result beat is checked in order.
// ----------------------------------------------------------------------------
module tb_sphere_view_cull_core;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned PHASE_ITEMS    = 62;
	localparam logic [svc_pkg::IdxW-1:0] REG_UNMAPPED = 3'd7;
	localparam logic [15:0] ONE_Q14 = 16'd16384;
	localparam logic [15:0] ONE_Q12 = 16'd4096;

	typedef struct {
		logic signed [svc_pkg::PosW-1:0] px;
		logic signed [svc_pkg::PosW-1:0] py;
		logic signed [svc_pkg::PosW-1:0] pz;
		logic [svc_pkg::RadW-1:0]        radius;
		logic [svc_pkg::OwnerW-1:0]      owner;
	} instance_t;

	typedef struct packed {
		logic             vis;
		svc_pkg::reason_t reason;
	} verdict_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [59:0]        cfg_data;
	logic               item_valid;
	logic               item_stall;
	logic signed [19:0] pos_x;
	logic signed [19:0] pos_y;
	logic signed [19:0] pos_z;
	logic [18:0]        bound_radius;
	logic [15:0]        owner_id;
	logic               result_valid;
	logic               result_stall;
	logic               visible;
	logic [2:0]         cull_reason;

	svc_pkg::cfg_t cam_regs;
	verdict_t   pending_verdicts[$];
	int         errors;
	int         send_idle_pct;
	int         stall_pct;
	int unsigned quiet_cycles;

	sphere_view_cull_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.bound_radius (bound_radius),
		.owner_id     (owner_id),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.visible      (visible),
		.cull_reason  (cull_reason)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Verdict predictor
	// ------------------------------------------------------------------

	// One camera axis: three Q1.14 weights against a Q.8 offset, Q.22 out
	function automatic longint axis_dot(logic [47:0] axis, longint rx, longint ry,
			longint rz);
		longint wx, wy, wz;
		wx = longint'($signed(axis[15:0]));
		wy = longint'($signed(axis[31:16]));
		wz = longint'($signed(axis[47:32]));
		return rx * wx + ry * wy + rz * wz;
	endfunction

	// Lateral test: projection scaled to Q.34 against the limit, both signs
	function automatic bit outside_limit(longint proj, longint limit);
		longint p;
		p = proj * 4096;
		return (p > limit) || (-p > limit);
	endfunction

	function automatic verdict_t cull_verdict(instance_t it, svc_pkg::cfg_t c);
		longint rx, ry, rz, rad, rt, fw, up;
		longint near_q8, far_q8, dmin, dmax, base, hrate, vrate, rmax, umax;
		verdict_t v;
		rx = longint'(it.px) - longint'($signed(c.cam_position[19:0]));
		ry = longint'(it.py) - longint'($signed(c.cam_position[39:20]));
		rz = longint'(it.pz) - longint'($signed(c.cam_position[59:40]));
		rad = longint'(it.radius);
		rt = axis_dot(c.rot_right, rx, ry, rz);
		fw = axis_dot(c.rot_forward, rx, ry, rz);
		up = axis_dot(c.rot_up, rx, ry, rz);
		near_q8 = longint'($signed(c.clip_range[19:0]));
		far_q8 = longint'($signed(c.clip_range[39:20]));
		dmin = (near_q8 - rad) * 16384;
		dmax = (far_q8 + rad) * 16384;
		base = fw + rad * 16384;
		hrate = longint'(c.view_rates[15:0]);
		vrate = longint'(c.view_rates[31:16]);
		rmax = hrate * base + rad * 67108864;
		umax = vrate * base + rad * 67108864;
		if (it.owner == c.hide_owner)
			v.reason = svc_pkg::REASON_OWNER;
		else if (fw > dmax)
			v.reason = svc_pkg::REASON_FAR;
		else if (fw < dmin)
			v.reason = svc_pkg::REASON_NEAR;
		else if (outside_limit(rt, rmax))
			v.reason = svc_pkg::REASON_SIDEWAYS;
		else if (outside_limit(up, umax))
			v.reason = svc_pkg::REASON_VERTICAL;
		else
			v.reason = svc_pkg::REASON_VISIBLE;
		v.vis = (v.reason == svc_pkg::REASON_VISIBLE);
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Item builders
	// ------------------------------------------------------------------
	function automatic instance_t make_inst(int x, int y, int z, int unsigned r,
			int unsigned o);
		instance_t it;
		it.px = 20'(x);
		it.py = 20'(y);
		it.pz = 20'(z);
		it.radius = 19'(r);
		it.owner = 16'(o);
		return it;
	endfunction

	// Signed Q12.8 value drawn from -span..span
	function automatic logic [19:0] rand_q8(int unsigned span);
		return 20'($urandom_range(2 * span) - span);
	endfunction

	// Every bit random
	function automatic instance_t wild_instance();
		instance_t it;
		it.px = 20'($urandom);
		it.py = 20'($urandom);
		it.pz = 20'($urandom);
		it.radius = 19'($urandom);
		it.owner = 16'($urandom);
		return it;
	endfunction

	// Near the camera, small sphere, owner often close to the hidden one
	function automatic instance_t scene_instance();
		instance_t it;
		it.px = 20'($signed(cam_regs.cam_position[19:0]) + $signed(rand_q8(65536)));
		it.py = 20'($signed(cam_regs.cam_position[39:20]) + $signed(rand_q8(65536)));
		it.pz = 20'($signed(cam_regs.cam_position[59:40]) + $signed(rand_q8(65536)));
		it.radius = ($urandom_range(9) == 0) ? 19'($urandom) : 19'($urandom_range(4096));
		it.owner = 16'($urandom_range(15));
		return it;
	endfunction

	function automatic svc_pkg::cfg_t scene_camera();
		svc_pkg::cfg_t c;
		c.cam_position = {rand_q8(20000), rand_q8(20000), rand_q8(20000)};
		c.rot_right = {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
			16'($urandom_range(32768) - 16384)};
		c.rot_forward = {16'($urandom_range(32768) - 16384),
			16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384)};
		c.rot_up = {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
			16'($urandom_range(32768) - 16384)};
		c.clip_range = {20'($urandom_range(200000)), rand_q8(2000)};
		c.view_rates = {16'($urandom_range(12288)), 16'($urandom_range(12288))};
		c.hide_owner = 16'($urandom_range(15));
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	// Register write; valid stays high so writes can go back to back
	task automatic cfg_write(logic [svc_pkg::IdxW-1:0] idx,
			logic [svc_pkg::DataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		unique case (idx)
			svc_pkg::REG_CAM_POSITION: cam_regs.cam_position = data[59:0];
			svc_pkg::REG_ROT_RIGHT:    cam_regs.rot_right = data[47:0];
			svc_pkg::REG_ROT_FORWARD:  cam_regs.rot_forward = data[47:0];
			svc_pkg::REG_ROT_UP:       cam_regs.rot_up = data[47:0];
			svc_pkg::REG_CLIP_RANGE:   cam_regs.clip_range = data[39:0];
			svc_pkg::REG_VIEW_RATES:   cam_regs.view_rates = data[31:0];
			svc_pkg::REG_HIDE_OWNER:   cam_regs.hide_owner = data[15:0];
			default: ;
		endcase
	endtask

	// Full camera load; bits above each narrower register's width carry junk
	task automatic program_camera(svc_pkg::cfg_t c);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		cfg_write(svc_pkg::REG_CAM_POSITION, c.cam_position);
		cfg_write(svc_pkg::REG_ROT_RIGHT, {junk[11:0], c.rot_right});
		cfg_write(svc_pkg::REG_ROT_FORWARD, {junk[23:12], c.rot_forward});
		cfg_write(svc_pkg::REG_ROT_UP, {junk[35:24], c.rot_up});
		cfg_write(svc_pkg::REG_CLIP_RANGE, {junk[19:0], c.clip_range});
		cfg_write(svc_pkg::REG_VIEW_RATES, {junk[27:0], c.view_rates});
		cfg_write(svc_pkg::REG_HIDE_OWNER, {junk[43:0], c.hide_owner});
		cfg_valid <= 1'b0;
	endtask

	// One instance beat, with a random lead-in gap
	task automatic send_instance(instance_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		pos_x <= it.px;
		pos_y <= it.py;
		pos_z <= it.pz;
		bound_radius <= it.radius;
		owner_id <= it.owner;
		do @(posedge clk); while (item_stall !== 1'b0);
		pending_verdicts.push_back(cull_verdict(it, cam_regs));
	endtask

	// Stop sending and let the pipeline empty
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset camera: owner 0 is hidden, clip planes both at zero
	task automatic test_reset_values();
		send_instance(make_inst(100, 0, 0, 0, 0));
		send_instance(make_inst(25600, 0, 0, 0, 1));
		send_instance(make_inst(-1, 0, 0, 0, 2));
		send_instance(make_inst(0, 300, -300, 0, 3));
	endtask

	// Axis-aligned camera; each reason in turn plus clip edges and extremes
	task automatic test_cull_reasons();
		svc_pkg::cfg_t c;
		wait_idle();
		c.cam_position = '0;
		c.rot_right = {16'd0, 16'd0, ONE_Q14};
		c.rot_forward = {16'd0, ONE_Q14, 16'd0};
		c.rot_up = {ONE_Q14, 16'd0, 16'd0};
		c.clip_range = {20'd256000, 20'd256};
		c.view_rates = {ONE_Q12, ONE_Q12};
		c.hide_owner = 16'd5;
		program_camera(c);
		send_instance(make_inst(0, 25600, 0, 0, 5));
		send_instance(make_inst(0, 512000, 0, 0, 1));
		send_instance(make_inst(0, 128, 0, 0, 1));
		send_instance(make_inst(51200, 25600, 0, 0, 1));
		send_instance(make_inst(-51200, 25600, 0, 0, 1));
		send_instance(make_inst(0, 25600, 51200, 0, 1));
		send_instance(make_inst(0, 25600, -51200, 0, 1));
		send_instance(make_inst(12800, 25600, -12800, 0, 1));
		// far and near planes touched exactly by the sphere
		send_instance(make_inst(0, 260000, 0, 4000, 1));
		send_instance(make_inst(0, 0, 0, 256, 1));
		send_instance(make_inst(-524288, -524288, -524288, 0, 0));
		send_instance(make_inst(524287, 524287, 524287, 524287, 16'hFFFF));
	endtask

	// Near plane behind the camera: an object behind it gives a negative limit
	task automatic test_negative_limit();
		wait_idle();
		cfg_write(svc_pkg::REG_CLIP_RANGE, 60'({20'd256000, 20'(-25600)}));
		cfg_write(svc_pkg::REG_VIEW_RATES, 60'({16'd0, ONE_Q12}));
		cfg_valid <= 1'b0;
		send_instance(make_inst(0, -12800, 0, 0, 1));
		wait_idle();
		cfg_write(svc_pkg::REG_VIEW_RATES, 60'({ONE_Q12, 16'd0}));
		cfg_valid <= 1'b0;
		send_instance(make_inst(0, -12800, 0, 0, 1));
	endtask

	// A write to an index past the map must leave the camera alone
	task automatic test_unmapped_index();
		wait_idle();
		cfg_write(REG_UNMAPPED, '1);
		cfg_valid <= 1'b0;
		send_instance(make_inst(0, -12800, 0, 0, 1));
	endtask

	// Camera settings from extremes to random scenes, under each idle mix
	task automatic test_random_scenes();
		svc_pkg::cfg_t c;
		instance_t it;
		logic [63:0] r0, r1, r2, r3, r4;
		for (int phase = 0; phase < 8; phase++) begin
			wait_idle();
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 84; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 84; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			if (phase == 0) begin
				c = '0;
			end else if (phase == 1) begin
				c = '1;
			end else if (phase == 2) begin
				r0 = {$urandom, $urandom};
				r1 = {$urandom, $urandom};
				r2 = {$urandom, $urandom};
				r3 = {$urandom, $urandom};
				r4 = {$urandom, $urandom};
				c.cam_position = r0[59:0];
				c.rot_right = r1[47:0];
				c.rot_forward = r2[47:0];
				c.rot_up = r3[47:0];
				c.clip_range = r4[39:0];
				c.view_rates = 32'(r1[63:48]) ^ r2[63:32];
				c.hide_owner = r3[63:48];
			end else begin
				c = scene_camera();
			end
			program_camera(c);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(9) < 3)
					it = wild_instance();
				else
					it = scene_instance();
				send_instance(it);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat: visible %b reason %0d", $time,
					visible, cull_reason);
			end else begin
				want = pending_verdicts.pop_front();
				if (visible !== want.vis) begin
					errors++;
					$display("%0t: visible mismatch: expected %b, actual %b", $time,
						want.vis, visible);
				end
				if (cull_reason !== want.reason) begin
					errors++;
					$display("%0t: cull_reason mismatch: expected %0d, actual %0d", $time,
						want.reason, cull_reason);
				end
			end
		end
	end

	// Receiver stall pattern
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	// Watchdog: too long with no beat on any channel
	always @(posedge clk) begin
		if ((item_valid === 1'b1 && item_stall === 1'b0) ||
				(result_valid === 1'b1 && result_stall === 1'b0) ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_sphere_view_cull_core: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		bound_radius = '0;
		owner_id = '0;
		result_stall = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		quiet_cycles = 0;
		cam_regs = '0;
		cam_regs.rot_right = svc_pkg::ROT_RESET;
		cam_regs.rot_forward = svc_pkg::ROT_RESET;
		cam_regs.rot_up = svc_pkg::ROT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_cull_reasons();
		test_negative_limit();
		test_unmapped_index();
		test_random_scenes();
		wait_idle();

		if (errors == 0)
			$display("tb_sphere_view_cull_core: clean");
		else
			$display("tb_sphere_view_cull_core: errors");
		$finish;
	end

endmodule

### filelist.f
rtl/core/svc_pkg.sv
rtl/core/svc_project.sv
rtl/core/svc_limit.sv
rtl/core/sphere_view_cull_core.sv
verif/tb_sphere_view_cull_core.sv
